// ----- rtl/pidsc_pkg.sv -----
`default_nettype none

package pidsc_pkg;

    localparam int IN_W      = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int ACC_W     = 32;
    localparam int GAIN_W    = 16;
    localparam int LIM_W     = 31;
    localparam int SCALE_W   = 16;
    localparam int DRIVE_W   = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic signed [GAIN_W-1:0] KP_RESET    = 16'sd15000;
    localparam logic signed [GAIN_W-1:0] KI_RESET    = 16'sd0;
    localparam logic signed [GAIN_W-1:0] KD_RESET    = 16'sd0;
    localparam logic        [LIM_W-1:0]  ILIM_RESET  = 31'd100;
    localparam logic        [SCALE_W-1:0] SCALE_RESET = 16'd1000;
    localparam logic        [LIM_W-1:0]  OLIM_RESET  = 31'd950;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7fff_ffff;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_ILIM  = 3'd3,
        REG_SCALE = 3'd4,
        REG_OLIM  = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAT,
        ST_ICLAMP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_OCLAMP,
        ST_OUT
    } pid_state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/pid_step_clamped_integer.sv -----
// pid controller step with a clamped error sum
//
// s_tvalid/s_tready/s_tdata bring one sample (target, measured) per transaction.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the gain, limit and scale
// registers; cfg_ready is always high, writes belong to idle periods.
// m_tvalid/m_tready/m_tdata/m_tuser return one result per sample: the drive
// value and, in tuser, the flag for a zero scale (raw weighted sum returned).
//
// with a nonzero scale, a sample passes the sequencer steps around the shared
// multiplier and the 48-step serial divider (one quotient bit per cycle); when
// the scale is zero, the divider is skipped.
// throughput: one sample at a time; s_tready is high only while the sequencer
// is idle. a finished result sits in the output register, so the next sample
// is taken while the receiver stalls; the sequencer holds its next result
// until the output register is free.
// reset: registers return to their default values, the error sum and the
// previous error are cleared and no result is pending.
`default_nettype none

module pid_step_clamped_integer
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [31:0]                           s_tdata,   // target_value, measured_value
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [pidsc_pkg::DRIVE_W-1:0]              m_tdata,   // drive_value
    output logic                                       m_tuser,   // scale_skipped
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pidsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pidsc_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import pidsc_pkg::*;

    logic signed [GAIN_W-1:0]  kp_reg;
    logic signed [GAIN_W-1:0]  ki_reg;
    logic signed [GAIN_W-1:0]  kd_reg;
    logic        [LIM_W-1:0]   ilim_reg;
    logic        [SCALE_W-1:0] scale_reg;
    logic        [LIM_W-1:0]   olim_reg;

    pid_state_t state_reg;
    pid_state_t state_next;

    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ACC_W-1:0]   sum_reg;
    logic signed [ACC_W-1:0]   accum_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [DRIVE_W-1:0] res_reg;
    logic                      skip_reg;
    logic                      m_tvalid_reg;
    logic [DRIVE_W-1:0]        m_tdata_reg;
    logic                      m_tuser_reg;

    mac_ctrl_t                 mac_ctrl;
    logic signed [GAIN_W-1:0]  mac_coef;
    logic signed [ACC_W-1:0]   mac_operand;
    logic signed [DRIVE_W-1:0] mac_total;
    logic                      div_start;
    logic                      div_done;
    logic signed [DRIVE_W-1:0] div_quotient;

    logic                      in_fire;
    logic                      out_load;
    logic signed [ACC_W:0]     sum_wide;
    logic signed [ACC_W-1:0]   sum_sat;
    logic signed [ACC_W-1:0]   ilim_pos;
    logic signed [ACC_W-1:0]   ilim_neg;
    logic signed [ACC_W-1:0]   sum_clamped;
    logic signed [DRIVE_W-1:0] olim_pos;
    logic signed [DRIVE_W-1:0] olim_neg;
    logic signed [DRIVE_W-1:0] drive_clamped;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= KP_RESET;
            ki_reg    <= KI_RESET;
            kd_reg    <= KD_RESET;
            ilim_reg  <= ILIM_RESET;
            scale_reg <= SCALE_RESET;
            olim_reg  <= OLIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP:    kp_reg    <= $signed(cfg_data[GAIN_W-1:0]);
                REG_KI:    ki_reg    <= $signed(cfg_data[GAIN_W-1:0]);
                REG_KD:    kd_reg    <= $signed(cfg_data[GAIN_W-1:0]);
                REG_ILIM:  ilim_reg  <= cfg_data[LIM_W-1:0];
                REG_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                REG_OLIM:  olim_reg  <= cfg_data[LIM_W-1:0];
                default:   ;
            endcase
        end
    end

    // error sum saturation and symmetric clamp
    assign sum_wide = {accum_reg[ACC_W-1], accum_reg}
                    + {{(ACC_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};

    always_comb
    begin
        if (!sum_wide[ACC_W] && sum_wide[ACC_W-1])
        begin
            sum_sat = ACC_MAX;
        end
        else if (sum_wide[ACC_W] && !sum_wide[ACC_W-1])
        begin
            sum_sat = ACC_MIN;
        end
        else
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    assign ilim_pos = $signed({1'b0, ilim_reg});
    assign ilim_neg = -ilim_pos;

    always_comb
    begin
        sum_clamped = sum_reg;
        if (ilim_reg != '0)
        begin
            if (sum_reg > ilim_pos)
            begin
                sum_clamped = ilim_pos;
            end
            else if (sum_reg < ilim_neg)
            begin
                sum_clamped = ilim_neg;
            end
        end
    end

    // output clamp
    assign olim_pos = $signed({{(DRIVE_W-LIM_W){1'b0}}, olim_reg});
    assign olim_neg = -olim_pos;

    always_comb
    begin
        drive_clamped = div_quotient;
        if (olim_reg != '0)
        begin
            if (div_quotient > olim_pos)
            begin
                drive_clamped = olim_pos;
            end
            else if (div_quotient < olim_neg)
            begin
                drive_clamped = olim_neg;
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mac_ctrl    = '0;
        mac_coef    = kp_reg;
        mac_operand = ACC_W'(err_reg);
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                state_next = ST_ICLAMP;
            end
            ST_ICLAMP:
            begin
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.acc_clr = 1'b1;
                state_next       = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.acc_add = 1'b1;
                mac_coef         = ki_reg;
                mac_operand      = accum_reg;
                state_next       = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.acc_add = 1'b1;
                mac_coef         = kd_reg;
                mac_operand      = ACC_W'(diff_reg);
                state_next       = ST_ACC;
            end
            ST_ACC:
            begin
                mac_ctrl.acc_add = 1'b1;
                state_next       = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (scale_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OCLAMP;
                end
            end
            ST_OCLAMP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_ICLAMP)
            begin
                accum_reg <= sum_clamped;
            end
            if (state_reg == ST_OCLAMP)
            begin
                prev_err_reg <= err_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            err_reg <= ERR_W'($signed(s_tdata[31:16])) - ERR_W'($signed(s_tdata[15:0]));
        end
        if (state_reg == ST_SAT)
        begin
            sum_reg  <= sum_sat;
            diff_reg <= DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
        end
        if (state_reg == ST_CHECK && scale_reg == '0)
        begin
            res_reg  <= mac_total;
            skip_reg <= 1'b1;
        end
        if (state_reg == ST_OCLAMP)
        begin
            res_reg  <= drive_clamped;
            skip_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= res_reg;
            m_tuser_reg <= skip_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    pidsc_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .total   (mac_total)
    );

    pidsc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mac_total),
        .divisor  (scale_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

endmodule

`default_nettype wire

// ----- rtl/pidsc_mac.sv -----
`default_nettype none

module pidsc_mac
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire pidsc_pkg::mac_ctrl_t                    ctrl,
    input  wire logic signed [pidsc_pkg::GAIN_W-1:0]     coef,
    input  wire logic signed [pidsc_pkg::ACC_W-1:0]      operand,
    output logic signed      [pidsc_pkg::DRIVE_W-1:0]    total
);
    import pidsc_pkg::*;

    logic signed [DRIVE_W-1:0] prod_reg;
    logic signed [DRIVE_W-1:0] acc_reg;

    // shared multiplier, product registered before accumulation
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * operand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign total = acc_reg;

endmodule

`default_nettype wire

// ----- rtl/pidsc_div.sv -----
`default_nettype none

module pidsc_div
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    input  wire logic signed [pidsc_pkg::DRIVE_W-1:0]    dividend,
    input  wire logic        [pidsc_pkg::SCALE_W-1:0]    divisor,
    output logic                                         done,
    output logic signed      [pidsc_pkg::DRIVE_W-1:0]    quotient
);
    import pidsc_pkg::*;

    localparam int CNT_W = $clog2(DRIVE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DRIVE_W - 1);

    logic                   busy_reg;
    logic                   fix_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DRIVE_W-1:0]     quo_reg;
    logic [SCALE_W-1:0]     rem_reg;
    logic [SCALE_W-1:0]     dsr_reg;

    logic [SCALE_W:0]       shifted;
    logic [SCALE_W+1:0]     trial;
    logic                   ge;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[DRIVE_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};
    assign ge      = !trial[SCALE_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DRIVE_W-1];
            quo_reg <= dividend[DRIVE_W-1] ? DRIVE_W'(-dividend) : DRIVE_W'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[SCALE_W-1:0] : shifted[SCALE_W-1:0];
            quo_reg <= {quo_reg[DRIVE_W-2:0], ge};
        end
        else if (fix_reg && neg_reg)
        begin
            quo_reg <= DRIVE_W'(-quo_reg);
        end
    end

    assign done     = done_reg;
    assign quotient = $signed(quo_reg);

endmodule

`default_nettype wire
